// ===== rtl/rita_pkg.sv =====
// Package for the radix integer to ASCII converter.
// Holds the item structs, the fixed constants and the digit-to-character function.
// It depends on nothing else.
`timescale 1ns / 1ps

package rita_pkg;

    // Default width of the converted value.
    localparam int VALUE_BITS_DEF = 32;

    // Fixed field widths.
    localparam int VALUE_W = 32;
    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 8;

    // Dividend bits retired by the divider in one clock cycle.
    localparam int STEP_BITS = 8;

    // Legal bases and the character map.
    localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_A     = 8'h61;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              last_char;
        logic              bad_radix;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT,
        S_DRAIN
    } t_state;

    // Maps a digit value to its lower-case ASCII character.
    function automatic logic [CHAR_W-1:0] f_digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_DIGITS) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DEC_DIGITS);
        end
        return c;
    endfunction

endpackage

// ===== rtl/radix_integer_to_ascii.sv =====
// Top level of the radix integer to ASCII converter: control sequencer,
// output register and assertions. Depends on rita_pkg, rita_div and rita_digit_mem.
`timescale 1ns / 1ps

// Usage
// An item (value and base) is transferred at a rising edge where start is high
// and busy is low. The block answers with one result transfer per character,
// most significant digit first, each marked by o_strobe for a single cycle; the
// last character of a conversion carries last_char. The receiver cannot stall,
// so every result is taken in the cycle it appears.
// Each digit costs one pass through the divider plus a write of the remainder
// into the digit store. Readback then streams one character per cycle from
// the store. Busy stays high while dividing, while reading and while the read
// pipeline drains.
// A base outside 2..36 gives one result with bad_radix set on the next cycle,
// and busy does not rise. A zero value gives the single character '0'.
// Reset (synchronous, active low) returns the sequencer to idle and clears the
// digit count; the digit store is not cleared, since every entry read back was
// written earlier by the same conversion.

module radix_integer_to_ascii #(
    parameter int VALUE_BITS = rita_pkg::VALUE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  rita_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output rita_pkg::t_out_item o_result
);

    localparam int ADDR_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);

    rita_pkg::t_state              r_state;
    rita_pkg::t_state              n_state;
    logic [CNT_W-1:0]              r_count;
    logic [rita_pkg::RADIX_W-1:0]  r_radix;
    logic [ADDR_W-1:0]             r_rd_idx;
    logic                          r_rd_vld;
    logic                          r_rd_last;
    logic                          r_out_valid;
    rita_pkg::t_out_item           r_out;

    logic                          w_accept;
    logic                          w_radix_ok;
    logic                          w_div_load;
    logic [VALUE_BITS-1:0]         w_div_dividend;
    logic                          w_div_done;
    logic [VALUE_BITS-1:0]         w_quot;
    logic [rita_pkg::DIGIT_W-1:0]  w_rem;
    logic                          w_quot_zero;
    logic                          w_wr_en;
    logic                          w_rd_en;
    logic [rita_pkg::DIGIT_W-1:0]  w_rd_data;

    assign w_radix_ok  = (i_item.radix >= rita_pkg::RADIX_MIN) &&
                         (i_item.radix <= rita_pkg::RADIX_MAX);
    assign w_quot_zero = (w_quot == '0);

    // Next-state logic. The divider runs once per digit; when the quotient
    // reaches zero, the stored digits are read back from the top entry down.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rita_pkg::S_IDLE: begin
                if (start && w_radix_ok) begin
                    n_state = rita_pkg::S_DIV;
                end
            end
            rita_pkg::S_DIV: begin
                if (w_div_done && w_quot_zero) begin
                    n_state = rita_pkg::S_EMIT;
                end
            end
            rita_pkg::S_EMIT: begin
                if (r_rd_idx == '0) begin
                    n_state = rita_pkg::S_DRAIN;
                end
            end
            rita_pkg::S_DRAIN: begin
                n_state = rita_pkg::S_IDLE;
            end
            default: begin
                n_state = rita_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs. The store is written only while dividing and read
    // only while emitting, so a read never meets a write to the same entry in
    // one cycle; the last write lands in the cycle before its readback begins.
    always_comb begin
        busy           = 1'b1;
        w_accept       = 1'b0;
        w_div_load     = 1'b0;
        w_div_dividend = w_quot;
        w_wr_en        = 1'b0;
        w_rd_en        = 1'b0;
        case (r_state)
            rita_pkg::S_IDLE: begin
                busy           = 1'b0;
                w_accept       = start;
                w_div_load     = start && w_radix_ok;
                w_div_dividend = VALUE_BITS'(i_item.value);
            end
            rita_pkg::S_DIV: begin
                w_wr_en    = w_div_done;
                w_div_load = w_div_done && !w_quot_zero;
            end
            rita_pkg::S_EMIT: begin
                w_rd_en = 1'b1;
            end
            rita_pkg::S_DRAIN: begin
                busy = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rita_pkg::S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_last   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_vld    <= w_rd_en;
            r_rd_last   <= w_rd_en && (r_rd_idx == '0);
            r_out_valid <= r_rd_vld || (w_accept && !w_radix_ok);
            if (w_accept) begin
                r_count <= '0;
            end else if (w_wr_en) begin
                r_count <= r_count + 1'b1;
            end
            if (w_wr_en && w_quot_zero) begin
                // The entry just written holds the most significant digit.
                r_rd_idx <= r_count[ADDR_W-1:0];
            end else if (w_rd_en) begin
                r_rd_idx <= r_rd_idx - 1'b1;
            end
        end
    end

    // Payload registers: the base is held for the whole conversion, and the
    // output register carries either the error result or a stored character.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_radix <= i_item.radix;
        end
        if (w_accept && !w_radix_ok) begin
            r_out.char_out  <= '0;
            r_out.last_char <= 1'b1;
            r_out.bad_radix <= 1'b1;
        end else if (r_rd_vld) begin
            r_out.char_out  <= rita_pkg::f_digit_char(w_rd_data);
            r_out.last_char <= r_rd_last;
            r_out.bad_radix <= 1'b0;
        end
    end

    rita_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_div_load),
        .i_dividend (w_div_dividend),
        .i_radix    ((r_state == rita_pkg::S_IDLE) ? i_item.radix : r_radix),
        .o_done     (w_div_done),
        .o_quotient (w_quot),
        .o_rem      (w_rem)
    );

    rita_digit_mem #(
        .DEPTH  (VALUE_BITS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (w_rem),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (w_rd_data)
    );

    assign o_strobe = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTH
    // A conversion never produces more digits than the store holds.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(VALUE_BITS))
        else $error("digit count exceeds store depth");

    // The divider only finishes while the sequencer waits for it.
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == rita_pkg::S_DIV))
        else $error("divider finished outside the divide phase");

    // An error result is always a single, final, zero character.
    a_bad_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.bad_radix) |->
        (o_result.last_char && (o_result.char_out == '0)))
        else $error("malformed bad radix result");

    // Characters of one conversion come out in consecutive cycles.
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last_char) |=> o_strobe)
        else $error("gap inside a character stream");

    // A valid base starts a conversion and raises busy.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && w_radix_ok) |=> busy)
        else $error("busy did not rise after a transfer");
`endif

endmodule

// ===== rtl/rita_digit_mem.sv =====
// Digit store of the radix converter: a synchronous single-port-write,
// registered-read memory of remainders. Depends on rita_pkg.
`timescale 1ns / 1ps

module rita_digit_mem #(
    parameter int DEPTH  = rita_pkg::VALUE_BITS_DEF,
    parameter int ADDR_W = $clog2(rita_pkg::VALUE_BITS_DEF)
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [ADDR_W-1:0]            i_wr_addr,
    input  logic [rita_pkg::DIGIT_W-1:0] i_wr_data,
    input  logic                         i_rd_en,
    input  logic [ADDR_W-1:0]            i_rd_addr,
    output logic [rita_pkg::DIGIT_W-1:0] o_rd_data
);

    logic [rita_pkg::DIGIT_W-1:0] r_mem [DEPTH];
    logic [rita_pkg::DIGIT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/rita_div.sv =====
// Iterative divider of the radix converter: divides the value by the base,
// retiring a fixed number of dividend bits per cycle. Depends on rita_pkg.
`timescale 1ns / 1ps

module rita_div #(
    parameter int VALUE_BITS = rita_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [VALUE_BITS-1:0]        i_dividend,
    input  logic [rita_pkg::RADIX_W-1:0] i_radix,
    output logic                         o_done,
    output logic [VALUE_BITS-1:0]        o_quotient,
    output logic [rita_pkg::DIGIT_W-1:0] o_rem
);

    localparam int STEP_BITS = rita_pkg::STEP_BITS;
    localparam int STEPS     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W     = STEPS * STEP_BITS;
    localparam int CNT_W     = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                         r_run;
    logic                         r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [PAD_W-1:0]             r_shift;
    logic [rita_pkg::DIGIT_W-1:0] r_rem;
    logic [PAD_W-1:0]             n_shift;
    logic [rita_pkg::DIGIT_W-1:0] n_rem;

    // Restoring division: the partial remainder stays below the base, so it
    // needs only one extra bit during each trial subtraction. Quotient bits
    // shift in at the bottom as dividend bits leave at the top.
    always_comb begin
        logic [rita_pkg::DIGIT_W:0]   trial;
        logic [rita_pkg::DIGIT_W-1:0] rem;
        logic [PAD_W-1:0]             sh;
        rem = r_rem;
        sh  = r_shift;
        for (int j = 0; j < STEP_BITS; j++) begin
            trial = {rem, sh[PAD_W-1]};
            sh    = {sh[PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, i_radix}) begin
                rem   = rita_pkg::DIGIT_W'(trial - {1'b0, i_radix});
                sh[0] = 1'b1;
            end else begin
                rem = trial[rita_pkg::DIGIT_W-1:0];
            end
        end
        n_shift = sh;
        n_rem   = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_shift <= PAD_W'(i_dividend);
            r_rem   <= '0;
        end else if (r_run) begin
            r_shift <= n_shift;
            r_rem   <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_shift[VALUE_BITS-1:0];
    assign o_rem      = r_rem;

endmodule
